FILE: rtl/hsl2rgb_pkg.sv
// hsl2rgb_pkg: fixed-point constants, payload structs and segment codes
// for the hsl to rgb converter. no dependencies.

package hsl2rgb_pkg;

    localparam int FRAC_BITS = 12;
    localparam int ONE_VAL   = 1 << FRAC_BITS;
    localparam int PIPE_DEPTH = 4;

    typedef logic [FRAC_BITS-1:0] t_frac;

    localparam t_frac C_MAX        = t_frac'(ONE_VAL - 1);
    localparam t_frac C_HALF       = t_frac'(ONE_VAL / 2);
    localparam t_frac C_THIRD      = t_frac'(ONE_VAL / 3);
    localparam t_frac C_SIXTH      = t_frac'(ONE_VAL / 6);
    localparam t_frac C_TWO_THIRDS = t_frac'((2 * ONE_VAL) / 3);
    localparam t_frac C_BLUE_OFS   = t_frac'(ONE_VAL - (ONE_VAL / 3));

    typedef struct packed {
        t_frac hue;
        t_frac saturation;
        t_frac lightness;
    } t_hsl;

    typedef struct packed {
        t_frac red;
        t_frac green;
        t_frac blue;
    } t_rgb;

    typedef enum logic [1:0] {
        SEG_RISE,
        SEG_HIGH,
        SEG_FALL,
        SEG_LOW
    } t_seg;

    // clamp a 13-bit unsigned sum to the fraction range
    function automatic t_frac sat_frac(input logic [FRAC_BITS:0] v);
        t_frac r;
        r = v[FRAC_BITS] ? C_MAX : v[FRAC_BITS-1:0];
        return r;
    endfunction

endpackage

FILE: rtl/hsl_to_rgb_converter.sv
// hsl_to_rgb_converter: four-stage pipelined hsl to rgb conversion in q0.12.
// depends on hsl2rgb_pkg.
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+----------------------------------
//  in      | i_valid | o_ready | i_pixel  (hue, saturation, lightness)
//  out     | o_valid | i_ready | o_pixel  (red, green, blue)
//
// one request per cycle unless the output stalls; stage 4 drives o_valid.
// stage 1 forms l*s, stage 2 forms q, p, q-p and the three hue angles,
// stage 3 runs one multiplier per channel, stage 4 adds p and saturates or picks q/p.
// each stage advances when it is empty or the stage after it advances, so
// bubbles close up under a stall and nothing is dropped or repeated.
// reset clears only the valid bits.

module hsl_to_rgb_converter
    import hsl2rgb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_hsl i_pixel,
    output logic o_valid,
    input  logic i_ready,
    output t_rgb o_pixel
);

    localparam int FB = FRAC_BITS;

    // stage registers
    logic  r_s1_valid, r_s2_valid, r_s3_valid, r_out_valid;
    t_frac r_s1_hue, r_s1_sat, r_s1_light, r_s1_prod;
    t_frac r_s2_q, r_s2_p, r_s2_d;
    t_frac r_s2_t [3];
    t_frac r_s3_q, r_s3_p;
    t_frac r_s3_prod [3];
    t_seg  r_s3_seg [3];
    t_rgb  r_out_pixel;

    logic w_en1, w_en2, w_en3, w_en4;

    logic [2*FB-1:0] n_s1_ls;
    logic [FB:0]     n_q_raw;
    t_frac           n_q;
    logic [FB+1:0]   n_p_raw;
    t_frac           n_p;
    t_frac           n_d;
    t_frac           n_t [3];
    t_seg            n_seg [3];
    logic [2*FB-1:0] n_prod [3];
    t_frac           n_chan [3];

    // stall chain
    assign w_en4   = !r_out_valid || i_ready;
    assign w_en3   = !r_s3_valid || w_en4;
    assign w_en2   = !r_s2_valid || w_en3;
    assign w_en1   = !r_s1_valid || w_en2;
    assign o_ready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_en1) r_s1_valid  <= i_valid;
            if (w_en2) r_s2_valid  <= r_s1_valid;
            if (w_en3) r_s3_valid  <= r_s2_valid;
            if (w_en4) r_out_valid <= r_s3_valid;
        end
    end

    // stage 1: l*s
    assign n_s1_ls = i_pixel.lightness * i_pixel.saturation;

    always_ff @(posedge i_clk) begin
        if (w_en1 && i_valid) begin
            r_s1_hue   <= i_pixel.hue;
            r_s1_sat   <= i_pixel.saturation;
            r_s1_light <= i_pixel.lightness;
            r_s1_prod  <= n_s1_ls[2*FB-1:FB];
        end
    end

    // stage 2: q, p, q - p and hue angles
    always_comb begin
        if (r_s1_light < C_HALF) begin
            n_q_raw = {1'b0, r_s1_light} + {1'b0, r_s1_prod};
        end else begin
            n_q_raw = {1'b0, r_s1_light} + {1'b0, r_s1_sat} - {1'b0, r_s1_prod};
        end
        n_q     = sat_frac(n_q_raw);
        n_p_raw = {1'b0, r_s1_light, 1'b0} - {2'b00, n_q};
        if (n_p_raw[FB+1]) begin
            n_p = '0;
        end else begin
            n_p = sat_frac(n_p_raw[FB:0]);
        end
        n_d = (n_q >= n_p) ? (n_q - n_p) : '0;
    end

    assign n_t[0] = r_s1_hue + C_THIRD;
    assign n_t[1] = r_s1_hue;
    assign n_t[2] = r_s1_hue + C_BLUE_OFS;

    always_ff @(posedge i_clk) begin
        if (w_en2 && r_s1_valid) begin
            r_s2_q <= n_q;
            r_s2_p <= n_p;
            r_s2_d <= n_d;
            r_s2_t <= n_t;
        end
    end

    // stage 3: one multiplier per channel
    for (genvar g = 0; g < 3; g++) begin : g_lane
        t_frac w_base;
        t_frac w_x6;

        always_comb begin
            priority if (r_s2_t[g] < C_SIXTH) begin
                n_seg[g] = SEG_RISE;
                w_base   = r_s2_t[g];
            end else if (r_s2_t[g] < C_HALF) begin
                n_seg[g] = SEG_HIGH;
                w_base   = '0;
            end else if (r_s2_t[g] < C_TWO_THIRDS) begin
                n_seg[g] = SEG_FALL;
                w_base   = C_TWO_THIRDS - r_s2_t[g];
            end else begin
                n_seg[g] = SEG_LOW;
                w_base   = '0;
            end
            w_x6 = t_frac'({3'b000, w_base} * (FB+3)'(6));
        end

        assign n_prod[g] = r_s2_d * w_x6;

        always_ff @(posedge i_clk) begin
            if (w_en3 && r_s2_valid) begin
                r_s3_prod[g] <= n_prod[g][2*FB-1:FB];
                r_s3_seg[g]  <= n_seg[g];
            end
        end

        // stage 4: add p and saturate on rise and fall, else pass q or p
        always_comb begin
            unique case (r_s3_seg[g])
                SEG_RISE, SEG_FALL: begin
                    n_chan[g] = sat_frac({1'b0, r_s3_p} + {1'b0, r_s3_prod[g]});
                end
                SEG_HIGH: begin
                    n_chan[g] = r_s3_q;
                end
                default: begin
                    n_chan[g] = r_s3_p;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3 && r_s2_valid) begin
            r_s3_q <= r_s2_q;
            r_s3_p <= r_s2_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en4 && r_s3_valid) begin
            r_out_pixel.red   <= n_chan[0];
            r_out_pixel.green <= n_chan[1];
            r_out_pixel.blue  <= n_chan[2];
        end
    end

    assign o_valid = r_out_valid;
    assign o_pixel = r_out_pixel;

endmodule

FILE: rtl/hsl2rgb_checker.sv
// hsl2rgb_checker: port-level checks on the hsl to rgb converter, bound to it.
// depends on hsl2rgb_pkg.

module hsl2rgb_checker
    import hsl2rgb_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input t_rgb o_pixel
);

    logic [2:0] r_inflight;
    logic       w_in_acc, w_out_acc;

    assign w_in_acc  = i_valid && o_ready;
    assign w_out_acc = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + {2'b00, w_in_acc} - {2'b00, w_out_acc};
        end
    end

    // never more requests held than stages
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= 3'(PIPE_DEPTH))
        else $error("more requests in flight than pipeline stages");

    // a free stage always lets a request in
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_inflight < 3'(PIPE_DEPTH)) |-> o_ready)
        else $error("input stalled with a free stage");

    // no result without a request in flight
    a_no_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_inflight != 3'd0))
        else $error("result shown with no request in flight");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_pixel)))
        else $error("stalled result changed");

    // reset empties the output
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind hsl_to_rgb_converter hsl2rgb_checker u_checker (.*);

FILE: dv/hsl_to_rgb_checker.sv
// hsl_to_rgb_checker: watches both channels of the hsl to rgb converter,
// predicts each pixel's rgb result and compares it with what comes out.
// depends on hsl2rgb_pkg.
`timescale 1ns / 100ps

module hsl_to_rgb_checker
    import hsl2rgb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_hsl i_in_pixel,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_rgb i_out_pixel,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_results
);

    localparam longint UNIT       = 64'd4096;
    localparam longint TOP_CODE   = UNIT - 1;
    localparam longint HALF_TURN  = UNIT / 2;
    localparam longint THIRD_TURN = UNIT / 3;
    localparam longint SIXTH_TURN = UNIT / 6;
    localparam longint TWO_THIRDS = (2 * UNIT) / 3;

    t_rgb rgb_expected_q[$];

    function automatic longint clamp_level(input longint v);
        longint r;
        r = (v < 0) ? 0 : ((v > TOP_CODE) ? TOP_CODE : v);
        return r;
    endfunction

    function automatic longint hue_ramp(input longint p, input longint q, input longint t);
        longint d;
        longint v;
        d = q - p;
        if (d < 0) begin
            d = 0;
        end
        if (t < SIXTH_TURN) begin
            v = p + (d * 6 * t) / UNIT;
        end else if (t < HALF_TURN) begin
            v = q;
        end else if (t < TWO_THIRDS) begin
            v = p + (d * (TWO_THIRDS - t) * 6) / UNIT;
        end else begin
            v = p;
        end
        return clamp_level(v);
    endfunction

    function automatic t_rgb predict_rgb(input t_hsl px);
        longint h;
        longint s;
        longint l;
        longint q;
        longint p;
        t_rgb   c;
        h = longint'(px.hue);
        s = longint'(px.saturation);
        l = longint'(px.lightness);
        if (s == 0) begin
            c.red   = t_frac'(l);
            c.green = t_frac'(l);
            c.blue  = t_frac'(l);
        end else begin
            if (l < HALF_TURN) begin
                q = (l * (UNIT + s)) / UNIT;
            end else begin
                q = l + s - (l * s) / UNIT;
            end
            q = clamp_level(q);
            p = clamp_level(2 * l - q);
            c.red   = t_frac'(hue_ramp(p, q, (h + THIRD_TURN) & TOP_CODE));
            c.green = t_frac'(hue_ramp(p, q, h));
            c.blue  = t_frac'(hue_ramp(p, q, (h - THIRD_TURN + UNIT) & TOP_CODE));
        end
        return c;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_results    = 0;
    end

    always @(posedge i_clk) begin
        t_rgb want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                rgb_expected_q.push_back(predict_rgb(i_in_pixel));
            end
            if (i_out_valid && i_out_ready) begin
                o_results = o_results + 1;
                if (rgb_expected_q.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    if (o_fail_count <= 10) begin
                        $display("result %0d arrived with no request outstanding: r=%0d g=%0d b=%0d",
                                 o_results, i_out_pixel.red, i_out_pixel.green,
                                 i_out_pixel.blue);
                    end
                end else begin
                    want = rgb_expected_q.pop_front();
                    if (want.red !== i_out_pixel.red || want.green !== i_out_pixel.green ||
                        want.blue !== i_out_pixel.blue) begin
                        o_fail_count = o_fail_count + 1;
                        if (o_fail_count <= 10) begin
                            $display("result %0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                     o_results, want.red, want.green, want.blue,
                                     i_out_pixel.red, i_out_pixel.green, i_out_pixel.blue);
                        end
                    end
                end
            end
            o_pending = rgb_expected_q.size();
        end
    end

endmodule

FILE: dv/tb_hsl_to_rgb_converter.sv
// tb_hsl_to_rgb_converter: drives directed hsl pixels back to back, then random
// ones under random source gaps, with random sink stalls; verdict from the checker.
// depends on hsl2rgb_pkg, hsl_to_rgb_converter and hsl_to_rgb_checker.
`timescale 1ns / 100ps

module tb_hsl_to_rgb_converter
    import hsl2rgb_pkg::*;
();

    localparam int RANDOM_PIXELS = 1030;
    localparam int IDLE_LIMIT    = 5000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    t_hsl in_pixel;
    logic out_valid;
    logic out_ready;
    t_rgb out_pixel;

    logic in_fire;
    int   idle_cycles;
    int   fail_count;
    int   pending;
    int   results;
    int   pixels_sent;
    int   gray_pixels;
    bit   src_busy;

    hsl_to_rgb_converter dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_ready (in_ready),
        .i_pixel (in_pixel),
        .o_valid (out_valid),
        .i_ready (out_ready),
        .o_pixel (out_pixel)
    );

    hsl_to_rgb_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_pixel   (in_pixel),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_pixel  (out_pixel),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results)
    );

    initial begin
        clk = 1'b0;
    end

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // handshakes sampled at the rising edge, read by the drivers at the falling edge
    always @(posedge clk) begin
        in_fire <= in_valid && in_ready;
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("hsl_to_rgb_converter: mismatch");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        int g;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            g = 0;
        end else if (r < 88) begin
            g = $urandom_range(1, 3);
        end else if (r < 97) begin
            g = $urandom_range(4, 10);
        end else begin
            g = $urandom_range(20, 40);
        end
        return g;
    endfunction

    function automatic t_hsl make_pixel(input int h, input int s, input int l);
        t_hsl px;
        px.hue        = t_frac'(h);
        px.saturation = t_frac'(s);
        px.lightness  = t_frac'(l);
        return px;
    endfunction

    function automatic t_hsl random_pixel();
        int   edges[10];
        int   r;
        t_hsl px;
        edges = '{0, 682, 1365, 2048, 2730, 3413, 2047, 681, 1364, 4095};
        px.hue = t_frac'($urandom_range(0, 4095));
        r = $urandom_range(0, 99);
        if (r < 15) begin
            px.hue = t_frac'(edges[$urandom_range(0, 9)] + $urandom_range(0, 2) - 1);
        end
        r = $urandom_range(0, 99);
        if (r < 10) begin
            px.saturation = '0;
        end else if (r < 15) begin
            px.saturation = t_frac'(4095);
        end else begin
            px.saturation = t_frac'($urandom_range(1, 4095));
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            px.lightness = '0;
        end else if (r < 8) begin
            px.lightness = t_frac'(4095);
        end else if (r < 14) begin
            px.lightness = t_frac'($urandom_range(2044, 2052));
        end else begin
            px.lightness = t_frac'($urandom_range(0, 4095));
        end
        return px;
    endfunction

    // entered and left at a falling edge
    task automatic send_pixel(input t_hsl px);
        int gap;
        gap = src_busy ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_pixel = px;
        do @(negedge clk); while (!in_fire);
        pixels_sent++;
        if (px.saturation == '0) begin
            gray_pixels++;
        end
    endtask

    task automatic drain_results();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // sink side: stretches of free flow alternate with random stalls
    initial begin
        int  stall;
        bit  free_run;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            free_run = ($urandom_range(0, 3) == 0);
            repeat (64) begin
                stall = free_run ? 0 : pick_gap();
                if (stall > 0) begin
                    out_ready = 1'b0;
                    repeat (stall) @(negedge clk);
                end
                out_ready = 1'b1;
                @(negedge clk);
            end
        end
    end

    initial begin
        t_hsl directed[$];
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_pixel    = '0;
        idle_cycles = 0;
        pixels_sent = 0;
        gray_pixels = 0;
        src_busy    = 1'b0;

        directed.push_back(make_pixel(0, 0, 0));
        directed.push_back(make_pixel(4095, 4095, 4095));
        directed.push_back(make_pixel(1234, 0, 4095));
        directed.push_back(make_pixel(4095, 0, 2048));
        directed.push_back(make_pixel(0, 4095, 2047));
        directed.push_back(make_pixel(0, 4095, 2048));
        directed.push_back(make_pixel(681, 4095, 2048));
        directed.push_back(make_pixel(682, 4095, 2048));
        directed.push_back(make_pixel(1364, 4095, 2048));
        directed.push_back(make_pixel(1365, 4095, 2048));
        directed.push_back(make_pixel(2047, 3000, 1500));
        directed.push_back(make_pixel(2048, 3000, 1500));
        directed.push_back(make_pixel(2729, 3000, 2600));
        directed.push_back(make_pixel(2730, 3000, 2600));
        directed.push_back(make_pixel(3412, 1, 1));
        directed.push_back(make_pixel(3413, 1, 4094));
        directed.push_back(make_pixel(4095, 4095, 1));
        directed.push_back(make_pixel(2730, 4095, 4095));
        directed.push_back(make_pixel(2048, 1, 0));
        directed.push_back(make_pixel(1024, 2048, 3072));
        directed.push_back(make_pixel(2730, 2730, 1365));

        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        src_busy = 1'b1;
        foreach (directed[i]) begin
            send_pixel(directed[i]);
        end
        drain_results();

        for (int n = 0; n < RANDOM_PIXELS; n++) begin
            if (n % 64 == 0) begin
                src_busy = ($urandom_range(0, 3) == 0);
            end
            if (n % 300 == 299) begin
                drain_results();
            end
            send_pixel(random_pixel());
        end
        drain_results();
        repeat (8) @(negedge clk);

        $display("%0d pixels converted (%0d gray, hue and lightness edges included)",
                 pixels_sent, gray_pixels);
        $display("%0d results checked, source gaps and sink stalls from none to %0d cycles",
                 results, 40);
        if (fail_count == 0 && pending == 0) begin
            $display("hsl_to_rgb_converter: match");
        end else begin
            $display("hsl_to_rgb_converter: mismatch");
        end
        $finish;
    end

endmodule

FILE: hsl_to_rgb_converter.f
rtl/hsl2rgb_pkg.sv
rtl/hsl_to_rgb_converter.sv
rtl/hsl2rgb_checker.sv
dv/hsl_to_rgb_checker.sv
dv/tb_hsl_to_rgb_converter.sv
